// ----- hdl/bmsufr_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsufr_pkg
// Shared types and constants of the battery monitor UART frame receiver.
// ----------------------------------------------------------------------------
package bmsufr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WORD_W      = ADDR_W - 1;
  localparam int POS_W       = 7;

  localparam logic [7:0] START_BYTE = 8'hDD;
  localparam logic [7:0] STOP_BYTE  = 8'h77;
  localparam logic [7:0] MAX_LEN    = 8'(MAX_PAYLOAD);
  localparam logic [15:0] ERR_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_WORD     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_CHECKSUM = 3'd2,
    KIND_STATUS   = 3'd3,
    KIND_LENGTH   = 3'd4,
    KIND_STOP     = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_CMD,
    ST_STATUS,
    ST_LENGTH,
    ST_DATA,
    ST_CKHI,
    ST_CKLO,
    ST_STOP,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic  clear_frame;
    logic  load_cmd;
    logic  load_status;
    logic  load_length;
    logic  store_data;
    logic  load_ck_hi;
    logic  load_ck_lo;
    logic  count_err;
    logic  emit;
    kind_t emit_kind;
    logic  word_clear;
    logic  word_read;
    logic  word_next;
  } ctrl_t;

  typedef struct packed {
    logic  is_start;
    logic  len_over;
    logic  len_zero;
    logic  data_done;
    logic  frame_bad;
    kind_t reason;
    logic  drain_last;
    logic  out_free;
  } status_t;

endpackage

// ----- hdl/bmsufr_if.sv -----
// ----------------------------------------------------------------------------
// bmsufr channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface bmsufr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bmsufr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  cmd_code;
  logic [4:0]  word_index;
  logic [15:0] word_value;
  logic        last;
  logic [15:0] error_total;

  modport source (output valid, output kind, output cmd_code, output word_index,
                  output word_value, output last, output error_total, input ready);
  modport sink   (input valid, input kind, input cmd_code, input word_index,
                  input word_value, input last, input error_total, output ready);
endinterface

// ----- hdl/bms_uart_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// bms_uart_frame_receiver_core
// Parses battery monitor reply frames from a UART byte stream into results.
// ----------------------------------------------------------------------------
// Byte transfers can be taken back to back while the receiver holds ready high.
// An error or empty-frame result shows in the cycle after the byte that caused it.
// A good frame drains its payload words after the stop byte, each word by a
// registered payload memory read then a result load that waits for a free result.
// Reset (synchronous, rst high) returns to waiting for a start byte, clears
// the error counter and drops any pending result; memory contents persist.
module bms_uart_frame_receiver_core (
  input  logic            clk,
  input  logic            rst,
  bmsufr_byte_if.sink     bytes,
  bmsufr_result_if.source results
);

  bmsufr_pkg::ctrl_t   ctrl;
  bmsufr_pkg::status_t status;
  logic                in_ready;

  // Controller: frame phases, then the payload drain loop.
  bmsufr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Datapath: fields, checksum, payload memory and result register.
  bmsufr_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (bytes.rx_byte),
    .ctrl    (ctrl),
    .status  (status),
    .results (results)
  );

  // Hold off byte transfers while a result waits and cannot be replaced, and while a payload drains.
  assign bytes.ready = in_ready;

endmodule

// ----- hdl/bmsufr_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmsufr_ctrl
// Frame parsing state machine; sequences the datapath by command signals.
// ----------------------------------------------------------------------------
module bmsufr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bmsufr_pkg::status_t  status,
  output bmsufr_pkg::ctrl_t    ctrl
);

  bmsufr_pkg::state_t state, state_next;
  logic receiving;
  logic xfer;

  assign receiving = state inside {bmsufr_pkg::ST_START, bmsufr_pkg::ST_CMD,
                                   bmsufr_pkg::ST_STATUS, bmsufr_pkg::ST_LENGTH,
                                   bmsufr_pkg::ST_DATA, bmsufr_pkg::ST_CKHI,
                                   bmsufr_pkg::ST_CKLO, bmsufr_pkg::ST_STOP};
  assign in_ready  = receiving && status.out_free;
  assign xfer      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmsufr_pkg::ST_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bmsufr_pkg::ST_START: begin
        if (xfer && status.is_start) state_next = bmsufr_pkg::ST_CMD;
      end
      bmsufr_pkg::ST_CMD: begin
        if (xfer) state_next = bmsufr_pkg::ST_STATUS;
      end
      bmsufr_pkg::ST_STATUS: begin
        if (xfer) state_next = bmsufr_pkg::ST_LENGTH;
      end
      bmsufr_pkg::ST_LENGTH: begin
        if (xfer) begin
          if (status.len_over)      state_next = bmsufr_pkg::ST_START;
          else if (status.len_zero) state_next = bmsufr_pkg::ST_CKHI;
          else                      state_next = bmsufr_pkg::ST_DATA;
        end
      end
      bmsufr_pkg::ST_DATA: begin
        if (xfer && status.data_done) state_next = bmsufr_pkg::ST_CKHI;
      end
      bmsufr_pkg::ST_CKHI: begin
        if (xfer) state_next = bmsufr_pkg::ST_CKLO;
      end
      bmsufr_pkg::ST_CKLO: begin
        if (xfer) state_next = bmsufr_pkg::ST_STOP;
      end
      bmsufr_pkg::ST_STOP: begin
        if (xfer) begin
          if (status.frame_bad || status.len_zero) state_next = bmsufr_pkg::ST_START;
          else                                     state_next = bmsufr_pkg::ST_READ;
        end
      end
      bmsufr_pkg::ST_READ: begin
        state_next = bmsufr_pkg::ST_LOAD;
      end
      bmsufr_pkg::ST_LOAD: begin
        if (status.out_free) begin
          state_next = status.drain_last ? bmsufr_pkg::ST_START : bmsufr_pkg::ST_READ;
        end
      end
      default: state_next = bmsufr_pkg::ST_START;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.emit_kind = bmsufr_pkg::KIND_WORD;
    case (state)
      bmsufr_pkg::ST_START: begin
        ctrl.clear_frame = xfer && status.is_start;
        ctrl.count_err   = xfer && !status.is_start;
      end
      bmsufr_pkg::ST_CMD:    ctrl.load_cmd    = xfer;
      bmsufr_pkg::ST_STATUS: ctrl.load_status = xfer;
      bmsufr_pkg::ST_LENGTH: begin
        ctrl.load_length = xfer;
        ctrl.count_err   = xfer && status.len_over;
        ctrl.emit        = xfer && status.len_over;
        ctrl.emit_kind   = bmsufr_pkg::KIND_LENGTH;
      end
      bmsufr_pkg::ST_DATA:   ctrl.store_data = xfer;
      bmsufr_pkg::ST_CKHI:   ctrl.load_ck_hi = xfer;
      bmsufr_pkg::ST_CKLO:   ctrl.load_ck_lo = xfer;
      bmsufr_pkg::ST_STOP: begin
        if (status.frame_bad) begin
          ctrl.count_err = xfer;
          ctrl.emit      = xfer;
          ctrl.emit_kind = status.reason;
        end else if (status.len_zero) begin
          ctrl.emit      = xfer;
          ctrl.emit_kind = bmsufr_pkg::KIND_EMPTY;
        end else begin
          ctrl.word_clear = xfer;
        end
      end
      bmsufr_pkg::ST_READ:   ctrl.word_read = 1'b1;
      bmsufr_pkg::ST_LOAD: begin
        ctrl.emit      = status.out_free;
        ctrl.word_next = status.out_free;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

// ----- hdl/bmsufr_datapath.sv -----
// ----------------------------------------------------------------------------
// bmsufr_datapath
// Frame fields, checksum sum, payload memory, error counter, result register.
// ----------------------------------------------------------------------------
module bmsufr_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_byte,
  input  bmsufr_pkg::ctrl_t    ctrl,
  output bmsufr_pkg::status_t  status,
  bmsufr_result_if.source      results
);

  logic [7:0]  command;
  logic [7:0]  frame_status;
  logic [7:0]  length;
  logic [bmsufr_pkg::POS_W-1:0]  position;
  logic [15:0] check;
  logic [15:0] sum;
  logic [15:0] err, err_next;
  logic [bmsufr_pkg::WORD_W-1:0] word;
  logic [7:0]  mem [bmsufr_pkg::STORE_DEPTH];
  logic [7:0]  rd_hi, rd_lo;
  logic [15:0] sum_add;
  logic [15:0] expect_sum;
  logic [7:0]  lo_index;
  logic        lo_ok;
  logic        out_valid;

  assign sum_add    = sum + {8'd0, rx_byte};
  assign expect_sum = 16'd0 - sum;
  assign err_next   = (ctrl.count_err && err != bmsufr_pkg::ERR_MAX) ? err + 16'd1 : err;
  assign lo_index   = {2'd0, word, 1'b1};
  assign lo_ok      = lo_index < length;

  always_comb begin
    status.is_start   = rx_byte == bmsufr_pkg::START_BYTE;
    status.len_over   = rx_byte > bmsufr_pkg::MAX_LEN;
    status.len_zero   = (ctrl.load_length ? rx_byte : length) == 8'd0;
    status.data_done  = ({1'b0, position} + 8'd1) >= length;
    status.drain_last = ({2'd0, word, 1'b0} + 8'd2) >= length;
    status.out_free   = !out_valid || results.ready;
    status.frame_bad  = 1'b1;
    if (check != expect_sum)             status.reason = bmsufr_pkg::KIND_CHECKSUM;
    else if (frame_status != 8'd0)       status.reason = bmsufr_pkg::KIND_STATUS;
    else if (rx_byte != bmsufr_pkg::STOP_BYTE) status.reason = bmsufr_pkg::KIND_STOP;
    else begin
      status.reason    = bmsufr_pkg::KIND_WORD;
      status.frame_bad = 1'b0;
    end
  end

  // frame fields and checksum accumulation
  always_ff @(posedge clk) begin
    if (ctrl.clear_frame) begin
      command      <= '0;
      frame_status <= '0;
      length       <= '0;
      position     <= '0;
      check        <= '0;
      sum          <= '0;
    end
    if (ctrl.load_cmd) command <= rx_byte;
    if (ctrl.load_status) begin
      frame_status <= rx_byte;
      sum          <= sum_add;
    end
    if (ctrl.load_length) begin
      length <= rx_byte;
      sum    <= sum_add;
    end
    if (ctrl.store_data) begin
      sum      <= sum_add;
      position <= position + (bmsufr_pkg::POS_W)'(1);
    end
    if (ctrl.load_ck_hi) check <= {rx_byte, 8'd0};
    if (ctrl.load_ck_lo) check <= {check[15:8], rx_byte};
    if (ctrl.word_clear) word <= '0;
    else if (ctrl.word_next) word <= word + (bmsufr_pkg::WORD_W)'(1);
  end

  // payload memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ctrl.store_data) mem[position[bmsufr_pkg::ADDR_W-1:0]] <= rx_byte;
    if (ctrl.word_read) begin
      rd_hi <= mem[{word, 1'b0}];
      rd_lo <= mem[{word, 1'b1}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err       <= '0;
      out_valid <= 1'b0;
    end else begin
      err <= err_next;
      if (ctrl.emit)          out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      results.kind        <= ctrl.emit_kind;
      results.cmd_code    <= command;
      results.error_total <= err_next;
      if (ctrl.emit_kind == bmsufr_pkg::KIND_WORD) begin
        results.word_index <= word;
        results.word_value <= {rd_hi, lo_ok ? rd_lo : 8'd0};
        results.last       <= status.drain_last;
      end else begin
        results.word_index <= '0;
        results.word_value <= '0;
        results.last       <= 1'b1;
      end
    end
  end

  assign results.valid = out_valid;

endmodule
